>>> rtl/core/avws_pkg.sv
// ----------------------------------------------------------------------------
// avws_pkg
// Shared widths, reset values and register indexes for the ADC voltmeter
// window statistics block.
// ----------------------------------------------------------------------------
package avws_pkg;

	// fixed field widths
	localparam int MV_W     = 13;   // millivolt results and full-scale register
	localparam int THRESH_W = 12;   // zero threshold register
	localparam int CNT_W    = 5;    // held_count result
	localparam int CFG_W    = 13;   // configuration write data
	localparam int CFG_IDX_W = 1;

	// parameter defaults
	localparam int WINDOW_DEPTH_DEF = 16;
	localparam int SAMPLE_BITS_DEF  = 12;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE     = 1'b1;

	// register reset values
	localparam logic [THRESH_W-1:0] ZERO_THRESHOLD_RST = 12'd10;
	localparam logic [MV_W-1:0]     FULL_SCALE_RST     = 13'd3300;

endpackage

>>> rtl/core/avws_scale.sv
// ----------------------------------------------------------------------------
// avws_scale
// Bit-serial scaler: quotient = value * scale / divisor, rounded down.
// One scale bit per cycle for the shift-add product, then one quotient bit
// per cycle for the restoring division. value must not exceed divisor.
// ----------------------------------------------------------------------------
module avws_scale #(
	parameter int W = 17
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [W-1:0]                value,
	input  logic [W-1:0]                divisor,
	input  logic [avws_pkg::MV_W-1:0]   scale,
	output logic                        done,
	output logic [avws_pkg::MV_W-1:0]   quotient
);

	localparam int MV_W  = avws_pkg::MV_W;
	localparam int ACC_W = W + MV_W;
	localparam int CNT_W = $clog2(MV_W);

	logic             busy_q;
	logic             div_phase_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;

	logic [W-1:0]     value_q;
	logic [W-1:0]     divisor_q;
	logic [MV_W-1:0]  scale_sr_q;
	logic [ACC_W-1:0] acc_q;

	logic [ACC_W-1:0] mul_next;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             q_bit;
	logic [W-1:0]     rem_next;
	logic [ACC_W-1:0] div_next;
	logic             last_step;

	always_comb begin
		mul_next  = {acc_q[ACC_W-2:0], 1'b0}
			+ (scale_sr_q[MV_W-1] ? ACC_W'(value_q) : ACC_W'(0));
		// partial remainder with the next numerator bit brought down
		trial     = {acc_q[ACC_W-1:MV_W], acc_q[MV_W-1]};
		diff      = trial - {1'b0, divisor_q};
		q_bit     = (trial >= {1'b0, divisor_q});
		rem_next  = q_bit ? diff[W-1:0] : trial[W-1:0];
		div_next  = {rem_next, acc_q[MV_W-2:0], q_bit};
		last_step = (cnt_q == CNT_W'(MV_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			div_phase_q <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (start) begin
			busy_q      <= 1'b1;
			div_phase_q <= 1'b0;
			done_q      <= 1'b0;
			cnt_q       <= '0;
		end else if (busy_q) begin
			cnt_q <= last_step ? '0 : cnt_q + 1'b1;
			if (last_step) begin
				if (div_phase_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					div_phase_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			value_q    <= value;
			divisor_q  <= divisor;
			scale_sr_q <= scale;
			acc_q      <= '0;
		end else if (busy_q) begin
			if (div_phase_q) begin
				acc_q <= div_next;
			end else begin
				acc_q      <= mul_next;
				scale_sr_q <= {scale_sr_q[MV_W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = acc_q[MV_W-1:0];

	// the remainder field stays below the divisor through the division
	assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && div_phase_q) |-> (acc_q[ACC_W-1:MV_W] < divisor_q))
		else $error("scaler remainder reached divisor");

	// a finished scaler never raises busy without a start
	assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && !start) |=> (done_q && !busy_q))
		else $error("scaler left done without a start");

	// a run finishes only after the last step of its division phase
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(done_q) |-> $past(div_phase_q && busy_q && last_step))
		else $error("scaler finished off its last step");

endmodule

>>> rtl/core/adc_voltmeter_window_stats_top.sv
// ----------------------------------------------------------------------------
// adc_voltmeter_window_stats_top
// Voltmeter statistics over a sliding window of converter codes.
// ----------------------------------------------------------------------------
// Each accepted code is zeroed below the threshold, stored in a circular
// window of WINDOW_DEPTH codes with a running sum, and folded into the
// lowest and highest code seen. One result transaction follows each input
// transaction: the ST_SUM state updates the running sum and starts four
// bit-serial scalers side by side, each running the shift-add product with
// full_scale_mv and then the restoring division by 4095 (or 4095 times the
// window count for the average), and the ST_RUN state hands the results to
// the output register. That handover waits while the output register still
// holds an untaken result. The input is ready again the cycle after the
// handover, so no new sample is taken while a result is still in progress.
// ----------------------------------------------------------------------------
module adc_voltmeter_window_stats_top #(
	parameter int WINDOW_DEPTH = avws_pkg::WINDOW_DEPTH_DEF,
	parameter int SAMPLE_BITS  = avws_pkg::SAMPLE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_we,
	input  logic [avws_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [avws_pkg::CFG_W-1:0]        cfg_data,
	// sample channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample_code,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [avws_pkg::MV_W-1:0]         current_mv,
	output logic [avws_pkg::MV_W-1:0]         low_mv,
	output logic [avws_pkg::MV_W-1:0]         high_mv,
	output logic [avws_pkg::MV_W-1:0]         average_mv,
	output logic [avws_pkg::CNT_W-1:0]        held_count
);

	localparam int MV_W   = avws_pkg::MV_W;
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int PTR_W  = $clog2(WINDOW_DEPTH);
	localparam int SUM_W  = SAMPLE_BITS + FILL_W;
	localparam int CMP_W  = (SAMPLE_BITS > avws_pkg::THRESH_W) ? SAMPLE_BITS
		: avws_pkg::THRESH_W;
	localparam int N_LANES = 4;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;

	logic [1:0]                     state_q;
	logic [avws_pkg::THRESH_W-1:0]  thresh_q;
	logic [MV_W-1:0]                full_scale_q;

	logic [SAMPLE_BITS-1:0]         window_mem [WINDOW_DEPTH];
	logic [PTR_W-1:0]               wr_ptr_q;
	logic [FILL_W-1:0]              fill_q;
	logic                           was_full_q;
	logic [SUM_W-1:0]               sum_q;
	logic [SAMPLE_BITS-1:0]         lowest_q;
	logic [SAMPLE_BITS-1:0]         highest_q;
	logic [SAMPLE_BITS-1:0]         code_q;
	logic [SAMPLE_BITS-1:0]         old_q;

	logic                           out_valid_q;
	logic [MV_W-1:0]                cur_mv_q;
	logic [MV_W-1:0]                low_mv_q;
	logic [MV_W-1:0]                high_mv_q;
	logic [MV_W-1:0]                avg_mv_q;
	logic [avws_pkg::CNT_W-1:0]     held_q;

	logic                           accept;
	logic [SAMPLE_BITS-1:0]         zcode;
	logic                           window_full;
	logic [SUM_W-1:0]               sum_next;
	logic [SUM_W-1:0]               avg_divisor;
	logic                           lane_start;
	logic                           result_load;
	logic [N_LANES-1:0]             lane_done;
	logic [MV_W-1:0]                lane_q [N_LANES];
	logic [SUM_W-1:0]               lane_value [N_LANES];
	logic [SUM_W-1:0]               lane_divisor [N_LANES];

	assign in_ready    = (state_q == ST_IDLE);
	assign accept      = in_valid && in_ready;
	assign window_full = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign lane_start  = (state_q == ST_SUM);
	assign result_load = (state_q == ST_RUN) && lane_done[0]
		&& (!out_valid_q || out_ready);

	always_comb begin
		zcode = (CMP_W'(sample_code) < CMP_W'(thresh_q)) ? '0 : sample_code;
		// drop the oldest code once the window had filled
		sum_next = sum_q + SUM_W'(code_q)
			- (was_full_q ? SUM_W'(old_q) : SUM_W'(0));
		// 4095 * count without a multiplier
		avg_divisor = {fill_q, {SAMPLE_BITS{1'b0}}} - SUM_W'(fill_q);

		lane_value[0]   = SUM_W'(code_q);
		lane_value[1]   = SUM_W'(lowest_q);
		lane_value[2]   = SUM_W'(highest_q);
		lane_value[3]   = sum_next;
		lane_divisor[0] = SUM_W'({SAMPLE_BITS{1'b1}});
		lane_divisor[1] = SUM_W'({SAMPLE_BITS{1'b1}});
		lane_divisor[2] = SUM_W'({SAMPLE_BITS{1'b1}});
		lane_divisor[3] = avg_divisor;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q     <= avws_pkg::ZERO_THRESHOLD_RST;
			full_scale_q <= avws_pkg::FULL_SCALE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				avws_pkg::REG_ZERO_THRESHOLD: thresh_q <= cfg_data[avws_pkg::THRESH_W-1:0];
				avws_pkg::REG_FULL_SCALE:     full_scale_q <= cfg_data[MV_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wr_ptr_q   <= '0;
			fill_q     <= '0;
			was_full_q <= 1'b0;
			sum_q      <= '0;
			lowest_q   <= '1;
			highest_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q    <= ST_SUM;
						was_full_q <= window_full;
						if (!window_full)
							fill_q <= fill_q + 1'b1;
						wr_ptr_q <= (wr_ptr_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0
							: wr_ptr_q + 1'b1;
						if (zcode < lowest_q)
							lowest_q <= zcode;
						if (zcode > highest_q)
							highest_q <= zcode;
					end
				end
				ST_SUM: begin
					sum_q   <= sum_next;
					state_q <= ST_RUN;
				end
				ST_RUN: begin
					if (result_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// window store: read the entry about to be overwritten, then replace it
	always_ff @(posedge clk) begin
		if (accept) begin
			old_q                <= window_mem[wr_ptr_q];
			window_mem[wr_ptr_q] <= zcode;
			code_q               <= zcode;
		end
	end

	genvar g;
	generate
		for (g = 0; g < N_LANES; g++) begin : g_lane
			avws_scale #(
				.W(SUM_W)
			) u_scale (
				.clk      (clk),
				.arst_n   (arst_n),
				.start    (lane_start),
				.value    (lane_value[g]),
				.divisor  (lane_divisor[g]),
				.scale    (full_scale_q),
				.done     (lane_done[g]),
				.quotient (lane_q[g])
			);
		end
	endgenerate

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (result_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			cur_mv_q  <= lane_q[0];
			low_mv_q  <= lane_q[1];
			high_mv_q <= lane_q[2];
			avg_mv_q  <= lane_q[3];
			held_q    <= avws_pkg::CNT_W'(fill_q);
		end
	end

	assign out_valid  = out_valid_q;
	assign current_mv = cur_mv_q;
	assign low_mv     = low_mv_q;
	assign high_mv    = high_mv_q;
	assign average_mv = avg_mv_q;
	assign held_count = held_q;

	// the scalers start together and must finish together
	assert property (@(posedge clk) disable iff (!arst_n)
		(lane_done == '0) || (lane_done == '1))
		else $error("scaler lanes out of step");

	// the fill count never passes the window depth
	assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("window fill overran");

	// once a sample is in, lowest never exceeds highest
	assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != '0) |-> (lowest_q <= highest_q))
		else $error("lowest code above highest code");

	// the running sum stays within 4095 per held code
	assert property (@(posedge clk) disable iff (!arst_n)
		sum_q <= avg_divisor)
		else $error("window sum out of range");

endmodule
